// ----- rtl/core/usbep_pkg.sv -----
// Shared constants and field-update functions for the USB endpoint register bank.
`default_nettype none
package usbep_pkg;

    localparam int DATA_W             = 16;
    localparam int EP_W               = 3;
    localparam int OP_W               = 2;
    localparam int ENDPOINT_COUNT_DEF = 8;

    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_EVENT = 2'd2;

    localparam logic [DATA_W-1:0] BIT_CTR_RX   = 16'h8000;
    localparam logic [DATA_W-1:0] MASK_STAT_RX = 16'h3000;
    localparam logic [DATA_W-1:0] BIT_SETUP    = 16'h0800;
    localparam logic [DATA_W-1:0] BIT_CTR_TX   = 16'h0080;
    localparam logic [DATA_W-1:0] MASK_STAT_TX = 16'h0030;
    localparam logic [DATA_W-1:0] MASK_TOGGLE  = 16'h7070;
    localparam logic [DATA_W-1:0] MASK_DIRECT  = 16'h070F;
    localparam logic [DATA_W-1:0] STAT_RX_NAK  = 16'h2000;
    localparam logic [DATA_W-1:0] STAT_TX_NAK  = 16'h0020;

    // toggle bits flip on 1, ctr bits clear on 0, setup is read only
    function automatic logic [DATA_W-1:0] apply_write(input logic [DATA_W-1:0] old_val,
                                                      input logic [DATA_W-1:0] wd);
        apply_write = ((old_val ^ wd) & MASK_TOGGLE)
                    | (old_val & wd & (BIT_CTR_RX | BIT_CTR_TX))
                    | (old_val & BIT_SETUP)
                    | (wd & MASK_DIRECT);
    endfunction

    function automatic logic [DATA_W-1:0] apply_event(input logic [DATA_W-1:0] old_val,
                                                      input logic rx,
                                                      input logic setup);
        if (rx)
        begin
            apply_event = (old_val & ~(MASK_STAT_RX | BIT_SETUP)) | BIT_CTR_RX | STAT_RX_NAK
                        | (setup ? BIT_SETUP : '0);
        end
        else
        begin
            apply_event = (old_val & ~MASK_STAT_TX) | BIT_CTR_TX | STAT_TX_NAK;
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/usb_endpoint_register_bank_top.sv -----
// USB device endpoint register bank: read, write and transfer-complete update.
//
//  channel | signals                                                            | dir
//  --------+--------------------------------------------------------------------+-----
//  in      | in_valid in_ready operation endpoint write_data rx_direction was_setup | in
//  out     | out_valid out_ready read_data                                      | out
//
// One word per cycle while no result is held: the addressed register is read,
// updated and written back in the accept cycle; the new value sits in the result
// register next cycle. in_ready drops only while a result is held by out_ready low.
// Reset clears all endpoint registers and the result valid flag.
`default_nettype none
module usb_endpoint_register_bank_top #(
    parameter int ENDPOINT_COUNT = usbep_pkg::ENDPOINT_COUNT_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [usbep_pkg::OP_W-1:0]     operation,
    input  wire logic [usbep_pkg::EP_W-1:0]     endpoint,
    input  wire logic [usbep_pkg::DATA_W-1:0]   write_data,
    input  wire logic                           rx_direction,
    input  wire logic                           was_setup,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [usbep_pkg::DATA_W-1:0]        read_data
);

    // only indexes reachable through the endpoint field get storage
    localparam int EP_SPAN = 1 << usbep_pkg::EP_W;
    localparam int DEPTH   = (ENDPOINT_COUNT < EP_SPAN) ? ENDPOINT_COUNT : EP_SPAN;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [usbep_pkg::DATA_W-1:0] ep_reg [DEPTH];
    logic [usbep_pkg::DATA_W-1:0] ep_next;
    logic [usbep_pkg::DATA_W-1:0] old_val;
    logic [usbep_pkg::DATA_W-1:0] result_reg;
    logic [usbep_pkg::DATA_W-1:0] result_next;
    logic                         out_valid_reg;
    logic [IDX_W-1:0]             idx;
    logic                         in_range;
    logic                         accept;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign read_data = result_reg;

    assign in_range = (32'(endpoint) < ENDPOINT_COUNT);
    assign idx      = IDX_W'(endpoint);
    assign old_val  = ep_reg[idx];

    always_comb
    begin
        case (operation)
            usbep_pkg::OP_WRITE: ep_next = usbep_pkg::apply_write(old_val, write_data);
            usbep_pkg::OP_EVENT: ep_next = usbep_pkg::apply_event(old_val, rx_direction,
                                                                   was_setup);
            default:             ep_next = old_val;
        endcase
        result_next = in_range ? ep_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DEPTH; i++)
            begin
                ep_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                out_valid_reg <= 1'b1;
                if (in_range)
                begin
                    ep_reg[idx] <= ep_next;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/usbep_checker.sv -----
// Port-level assertions for the USB endpoint register bank, bound to the top level.
`default_nettype none
module usbep_checker #(
    parameter int ENDPOINT_COUNT = usbep_pkg::ENDPOINT_COUNT_DEF
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic [usbep_pkg::OP_W-1:0]    operation,
    input wire logic [usbep_pkg::EP_W-1:0]    endpoint,
    input wire logic                          rx_direction,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [usbep_pkg::DATA_W-1:0]  read_data
);

    logic acc;
    assign acc = in_valid && in_ready;

    // a held result blocks new words
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input accepted while result stalled");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> out_valid)
        else $error("accepted word produced no result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(read_data)))
        else $error("stalled result changed");

    // receive completion on an in-range endpoint shows ctr_rx set and rx status NAK
    a_rx_event: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && operation == usbep_pkg::OP_EVENT && rx_direction
         && 32'(endpoint) < ENDPOINT_COUNT)
        |=> (((read_data & usbep_pkg::BIT_CTR_RX) != '0)
             && ((read_data & usbep_pkg::MASK_STAT_RX) == usbep_pkg::STAT_RX_NAK)))
        else $error("receive event result wrong");

    // two back-to-back reads of one endpoint agree
    a_read_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && operation == usbep_pkg::OP_READ)
        ##1 (acc && operation == usbep_pkg::OP_READ && endpoint == $past(endpoint))
        |=> (read_data == $past(read_data)))
        else $error("repeated read differs");

endmodule

bind usb_endpoint_register_bank_top usbep_checker #(
    .ENDPOINT_COUNT(ENDPOINT_COUNT)
) u_usbep_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .endpoint     (endpoint),
    .rx_direction (rx_direction),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data)
);
`default_nettype wire
